>>> rtl/dc2d_pkg.sv
// shared constants, opcode and register codes for the direct convolution engine
// and the round/saturate helper; no dependencies
package dc2d_pkg;

	localparam int VW   = 16;   // Q8.8 value width
	localparam int IDXW = 12;   // item index width
	localparam int OPW  = 3;    // opcode width
	localparam int CFGW = 7;    // config data width (widest register)
	localparam int GW   = 20;   // signed geometry / address arithmetic width
	localparam int PW   = 18;   // unsigned geometry product width
	localparam int MW   = 18;   // shared multiplier operand width
	localparam int ACCW = 48;   // accumulator width

	// opcodes
	localparam logic [OPW-1:0] OP_WR_ACT  = 3'd0;
	localparam logic [OPW-1:0] OP_WR_WGT  = 3'd1;
	localparam logic [OPW-1:0] OP_WR_BIAS = 3'd2;
	localparam logic [OPW-1:0] OP_COMPUTE = 3'd3;
	localparam logic [OPW-1:0] OP_READ    = 3'd4;

	// register indexes
	localparam logic [2:0] REG_IN_CH   = 3'd0;
	localparam logic [2:0] REG_OUT_CH  = 3'd1;
	localparam logic [2:0] REG_IN_H    = 3'd2;
	localparam logic [2:0] REG_IN_W    = 3'd3;
	localparam logic [2:0] REG_K_H     = 3'd4;
	localparam logic [2:0] REG_K_W     = 3'd5;
	localparam logic [2:0] REG_STRIDE  = 3'd6;
	localparam logic [2:0] REG_PADDING = 3'd7;

	// result kinds and status
	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_READ = 1'b1;
	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_BAD  = 1'b1;

	// Q16.16 sum to Q8.8, round half up, saturate
	function automatic logic signed [VW-1:0] round_sat(input logic signed [ACCW-1:0] acc);
		logic signed [ACCW-1:0] r;
		logic signed [ACCW-9:0] q;
		r = acc + 48'sd128;
		q = r[ACCW-1:8];
		if (q > 40'sd32767)
			return 16'sh7fff;
		else if (q < -40'sd32768)
			return 16'sh8000;
		else
			return q[VW-1:0];
	endfunction

endpackage

>>> rtl/direct_conv2d_engine.sv
// direct 2D convolution engine: stores, geometry setup and shared-multiplier MAC sequencer
// depends on dc2d_pkg
//
// Loads (activation, weight, bias) are written when accepted; a read result passes from
// the read data register through ST_RD to the result register. A compute item first checks
// the geometry, finds the output size by repeated subtraction of the stride and works
// out the store layout with nine products on the shared multiplier. Each output position
// then runs ST_POS, in_channels*kernel_height*kernel_width taps in ST_TAP, one tap per
// cycle through the single 18x18 multiplier (which sets the compute time), ST_DR1, ST_DR2
// and ST_WR. The input is stalled for the whole compute; stores need no clearing after reset.
module direct_conv2d_engine import dc2d_pkg::*; #(
	parameter int ACT_DEPTH    = 4096,
	parameter int WEIGHT_DEPTH = 4096,
	parameter int OUT_DEPTH    = 4096,
	parameter int MAX_CHANNELS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFGW-1:0]       cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OPW-1:0]        opcode,
	input  logic [IDXW-1:0]       index,
	input  logic signed [VW-1:0]  value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  kind,
	output logic                  status,
	output logic signed [VW-1:0]  read_value
);

	localparam int AAW = $clog2(ACT_DEPTH);
	localparam int WAW = $clog2(WEIGHT_DEPTH);
	localparam int OAW = $clog2(OUT_DEPTH);
	localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_CHK, ST_DIV, ST_MUL, ST_TOT,
		ST_POS, ST_TAP, ST_DR1, ST_DR2, ST_WR
	} state_t;

	state_t state_q;

	// configuration registers
	logic [4:0] in_ch_q, out_ch_q;
	logic [6:0] in_h_q, in_w_q;
	logic [2:0] k_h_q, k_w_q, stride_q;
	logic [1:0] pad_q;

	// setup registers
	logic [3:0]    step_q;
	logic [7:0]    rem_h_q, rem_w_q, oh_n_q, ow_n_q;
	logic [PW-1:0] ihw_q, wk_q, siw_q, piw_q, act_tot_q, wpo_q, w_tot_q, out_tot_q;

	// loop counters and incremental addresses
	logic [4:0]            oc_q, ic_q;
	logic [7:0]            oh_q, ow_q;
	logic [2:0]            kh_q, kw_q;
	logic signed [8:0]     ihb_q, iwb_q, ih_q, iw_q;
	logic signed [GW-1:0]  ihbw_q, rowoff_q, ic_base_q;
	logic [GW-1:0]         wbase_q, waddr_q, oaddr_q;

	// MAC pipeline
	logic                  v_s1, v_s2;
	logic [VW-1:0]         act_rd_s1, w_rd_s1;
	logic signed [MW-1:0]  mul_a, mul_b;
	logic signed [2*MW-1:0] prod_q;
	logic signed [ACCW-1:0] acc_q;

	// result register
	logic                 out_valid_q, kind_q, status_q;
	logic signed [VW-1:0] read_value_q;

	// stores
	logic [VW-1:0] act_mem [ACT_DEPTH];
	logic [VW-1:0] w_mem   [WEIGHT_DEPTH];
	logic [VW-1:0] out_mem [OUT_DEPTH];
	logic [VW-1:0] bias_q  [MAX_CHANNELS];
	logic [VW-1:0] rd_data_q;
	logic          rd_oob_q;

	logic                 in_acc, out_acc;
	logic [16:0]          idx_ext;
	logic signed [GW-1:0] act_sum;
	logic                 tap_ok, tap_last, pos_last_ow, pos_last_oh, pos_last_oc;
	logic [7:0]           span_h, span_w;
	logic                 geom_bad;
	logic [VW-1:0]        bias_cur;

	// handshakes
	assign in_acc     = in_valid & ~in_stall;
	assign out_acc    = out_valid_q & ~out_stall;
	assign in_stall   = (state_q != ST_IDLE) | (out_valid_q & out_stall);
	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign idx_ext    = 17'(index);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q  <= 5'd1;
			out_ch_q <= 5'd1;
			in_h_q   <= 7'd28;
			in_w_q   <= 7'd28;
			k_h_q    <= 3'd5;
			k_w_q    <= 3'd5;
			stride_q <= 3'd1;
			pad_q    <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_CH:   in_ch_q  <= cfg_data[4:0];
				REG_OUT_CH:  out_ch_q <= cfg_data[4:0];
				REG_IN_H:    in_h_q   <= cfg_data[6:0];
				REG_IN_W:    in_w_q   <= cfg_data[6:0];
				REG_K_H:     k_h_q    <= cfg_data[2:0];
				REG_K_W:     k_w_q    <= cfg_data[2:0];
				REG_STRIDE:  stride_q <= cfg_data[2:0];
				REG_PADDING: pad_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// geometry checks that need no products
	assign span_h   = {1'b0, in_h_q} + {5'b0, pad_q, 1'b0};
	assign span_w   = {1'b0, in_w_q} + {5'b0, pad_q, 1'b0};
	assign geom_bad = (in_ch_q == 5'd0) || (out_ch_q == 5'd0) || (in_h_q == 7'd0) ||
		(in_w_q == 7'd0) || (k_h_q == 3'd0) || (k_w_q == 3'd0) || (stride_q == 3'd0) ||
		(9'(in_ch_q) > 9'(MAX_CHANNELS)) || (9'(out_ch_q) > 9'(MAX_CHANNELS)) ||
		(span_h < 8'(k_h_q)) || (span_w < 8'(k_w_q));

	// tap address and border test
	assign act_sum = ic_base_q + rowoff_q + GW'(iw_q);
	assign tap_ok  = (ih_q >= 9'sd0) && (ih_q < $signed({2'b0, in_h_q})) &&
		(iw_q >= 9'sd0) && (iw_q < $signed({2'b0, in_w_q}));
	assign tap_last = (kw_q == k_w_q - 3'd1) && (kh_q == k_h_q - 3'd1) &&
		(ic_q == in_ch_q - 5'd1);
	assign pos_last_ow = (ow_q == ow_n_q - 8'd1);
	assign pos_last_oh = (oh_q == oh_n_q - 8'd1);
	assign pos_last_oc = (oc_q == out_ch_q - 5'd1);
	assign bias_cur    = bias_q[CHW'(oc_q)];

	// shared multiplier operands: layout products during setup, taps otherwise
	always_comb begin
		mul_a = MW'($signed(act_rd_s1));
		mul_b = MW'($signed(w_rd_s1));
		if (state_q == ST_MUL) begin
			case (step_q)
				4'd0: begin mul_a = MW'(in_h_q);   mul_b = MW'(in_w_q);     end
				4'd1: begin mul_a = MW'(k_h_q);    mul_b = MW'(k_w_q);      end
				4'd2: begin mul_a = MW'(stride_q); mul_b = MW'(in_w_q);     end
				4'd3: begin mul_a = MW'(pad_q);    mul_b = MW'(in_w_q);     end
				4'd4: begin mul_a = MW'(in_ch_q);  mul_b = MW'(ihw_q);      end
				4'd5: begin mul_a = MW'(in_ch_q);  mul_b = MW'(wk_q);       end
				4'd6: begin mul_a = MW'(out_ch_q); mul_b = prod_q[MW-1:0];  end
				4'd7: begin mul_a = MW'(oh_n_q);   mul_b = MW'(ow_n_q);     end
				4'd8: begin mul_a = MW'(out_ch_q); mul_b = prod_q[MW-1:0];  end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// activation and weight stores
	always_ff @(posedge clk) begin
		if (in_acc && opcode == OP_WR_ACT && idx_ext < 17'(ACT_DEPTH))
			act_mem[idx_ext[AAW-1:0]] <= value;
		act_rd_s1 <= act_mem[act_sum[AAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (in_acc && opcode == OP_WR_WGT && idx_ext < 17'(WEIGHT_DEPTH))
			w_mem[idx_ext[WAW-1:0]] <= value;
		w_rd_s1 <= w_mem[waddr_q[WAW-1:0]];
	end

	// output store
	always_ff @(posedge clk) begin
		if (state_q == ST_WR)
			out_mem[oaddr_q[OAW-1:0]] <= round_sat(acc_q);
		if (in_acc && opcode == OP_READ) begin
			rd_data_q <= out_mem[idx_ext[OAW-1:0]];
			rd_oob_q  <= (idx_ext >= 17'(OUT_DEPTH));
		end
	end

	// bias store, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++)
				bias_q[i] <= '0;
		end else if (in_acc && opcode == OP_WR_BIAS && idx_ext < 17'(MAX_CHANNELS)) begin
			bias_q[CHW'(idx_ext)] <= value;
		end
	end

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			rem_h_q      <= '0;
			rem_w_q      <= '0;
			oh_n_q       <= '0;
			ow_n_q       <= '0;
			ihw_q        <= '0;
			wk_q         <= '0;
			siw_q        <= '0;
			piw_q        <= '0;
			act_tot_q    <= '0;
			wpo_q        <= '0;
			w_tot_q      <= '0;
			out_tot_q    <= '0;
			oc_q         <= '0;
			ic_q         <= '0;
			oh_q         <= '0;
			ow_q         <= '0;
			kh_q         <= '0;
			kw_q         <= '0;
			ihb_q        <= '0;
			iwb_q        <= '0;
			ih_q         <= '0;
			iw_q         <= '0;
			ihbw_q       <= '0;
			rowoff_q     <= '0;
			ic_base_q    <= '0;
			wbase_q      <= '0;
			waddr_q      <= '0;
			oaddr_q      <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= KIND_DONE;
			status_q     <= STAT_OK;
			read_value_q <= '0;
		end else begin
			if (out_acc)
				out_valid_q <= 1'b0;

			// tap pipeline: read, multiply, accumulate
			v_s1 <= (state_q == ST_TAP) && tap_ok;
			v_s2 <= v_s1;
			if (v_s2)
				acc_q <= acc_q + ACCW'(prod_q);

			case (state_q)
				ST_IDLE: begin
					if (in_acc && opcode == OP_READ)
						state_q <= ST_RD;
					else if (in_acc && opcode == OP_COMPUTE)
						state_q <= ST_CHK;
				end
				ST_RD: begin
					out_valid_q  <= 1'b1;
					kind_q       <= KIND_READ;
					status_q     <= STAT_OK;
					read_value_q <= rd_oob_q ? '0 : rd_data_q;
					state_q      <= ST_IDLE;
				end
				ST_CHK: begin
					if (geom_bad) begin
						out_valid_q  <= 1'b1;
						kind_q       <= KIND_DONE;
						status_q     <= STAT_BAD;
						read_value_q <= '0;
						state_q      <= ST_IDLE;
					end else begin
						rem_h_q <= span_h - 8'(k_h_q);
						rem_w_q <= span_w - 8'(k_w_q);
						oh_n_q  <= 8'd1;
						ow_n_q  <= 8'd1;
						state_q <= ST_DIV;
					end
				end
				// output size by repeated subtraction of the stride
				ST_DIV: begin
					if (rem_h_q >= 8'(stride_q)) begin
						rem_h_q <= rem_h_q - 8'(stride_q);
						oh_n_q  <= oh_n_q + 8'd1;
					end
					if (rem_w_q >= 8'(stride_q)) begin
						rem_w_q <= rem_w_q - 8'(stride_q);
						ow_n_q  <= ow_n_q + 8'd1;
					end
					if (rem_h_q < 8'(stride_q) && rem_w_q < 8'(stride_q)) begin
						step_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				// layout products, each captured one step after issue
				ST_MUL: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd1: ihw_q     <= prod_q[PW-1:0];
						4'd2: wk_q      <= prod_q[PW-1:0];
						4'd3: siw_q     <= prod_q[PW-1:0];
						4'd4: piw_q     <= prod_q[PW-1:0];
						4'd5: act_tot_q <= prod_q[PW-1:0];
						4'd6: wpo_q     <= prod_q[PW-1:0];
						4'd7: w_tot_q   <= prod_q[PW-1:0];
						4'd9: out_tot_q <= prod_q[PW-1:0];
						default: ;
					endcase
					if (step_q == 4'd9)
						state_q <= ST_TOT;
				end
				ST_TOT: begin
					if (act_tot_q > PW'(ACT_DEPTH) || w_tot_q > PW'(WEIGHT_DEPTH) ||
						out_tot_q > PW'(OUT_DEPTH)) begin
						out_valid_q  <= 1'b1;
						kind_q       <= KIND_DONE;
						status_q     <= STAT_BAD;
						read_value_q <= '0;
						state_q      <= ST_IDLE;
					end else begin
						oc_q    <= '0;
						oh_q    <= '0;
						ow_q    <= '0;
						ihb_q   <= 9'd0 - 9'(pad_q);
						iwb_q   <= 9'd0 - 9'(pad_q);
						ihbw_q  <= GW'(0) - GW'(piw_q);
						wbase_q <= '0;
						oaddr_q <= '0;
						state_q <= ST_POS;
					end
				end
				// start of one output position
				ST_POS: begin
					ic_q      <= '0;
					kh_q      <= '0;
					kw_q      <= '0;
					ic_base_q <= '0;
					ih_q      <= ihb_q;
					iw_q      <= iwb_q;
					rowoff_q  <= ihbw_q;
					waddr_q   <= wbase_q;
					acc_q     <= {{(ACCW-VW-8){bias_cur[VW-1]}}, bias_cur, 8'd0};
					state_q   <= ST_TAP;
				end
				// one tap per cycle, kernel column innermost
				ST_TAP: begin
					waddr_q <= waddr_q + GW'(1);
					if (kw_q == k_w_q - 3'd1) begin
						kw_q <= '0;
						iw_q <= iwb_q;
						if (kh_q == k_h_q - 3'd1) begin
							kh_q     <= '0;
							ih_q     <= ihb_q;
							rowoff_q <= ihbw_q;
							if (ic_q != in_ch_q - 5'd1) begin
								ic_q      <= ic_q + 5'd1;
								ic_base_q <= ic_base_q + GW'(ihw_q);
							end
						end else begin
							kh_q     <= kh_q + 3'd1;
							ih_q     <= ih_q + 9'sd1;
							rowoff_q <= rowoff_q + GW'(in_w_q);
						end
					end else begin
						kw_q <= kw_q + 3'd1;
						iw_q <= iw_q + 9'sd1;
					end
					if (tap_last)
						state_q <= ST_DR1;
				end
				ST_DR1: state_q <= ST_DR2;
				ST_DR2: state_q <= ST_WR;
				// store the rounded output and move to the next position
				ST_WR: begin
					oaddr_q <= oaddr_q + GW'(1);
					state_q <= ST_POS;
					if (pos_last_ow) begin
						ow_q  <= '0;
						iwb_q <= 9'd0 - 9'(pad_q);
						if (pos_last_oh) begin
							oh_q   <= '0;
							ihb_q  <= 9'd0 - 9'(pad_q);
							ihbw_q <= GW'(0) - GW'(piw_q);
							if (pos_last_oc) begin
								out_valid_q  <= 1'b1;
								kind_q       <= KIND_DONE;
								status_q     <= STAT_OK;
								read_value_q <= '0;
								state_q      <= ST_IDLE;
							end else begin
								oc_q    <= oc_q + 5'd1;
								wbase_q <= wbase_q + GW'(wpo_q);
							end
						end else begin
							oh_q   <= oh_q + 8'd1;
							ihb_q  <= ihb_q + $signed(9'(stride_q));
							ihbw_q <= ihbw_q + GW'(siw_q);
						end
					end else begin
						ow_q  <= ow_q + 8'd1;
						iwb_q <= iwb_q + $signed(9'(stride_q));
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input not stalled during a busy item");

	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_READ) |-> (status == STAT_OK))
		else $error("read item with bad status");

	a_done_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_DONE) |-> (read_value == '0))
		else $error("compute item with nonzero value");

	a_tap_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAP && tap_ok) |->
		(act_sum >= 0 && act_sum < $signed(GW'(ACT_DEPTH))))
		else $error("tap address outside activation store");

endmodule

>>> tb/dc2d_checker.sv
// result checker for direct_conv2d_engine: mirrors the config port and both channels,
// predicts each result from its own copy of the stores and compares; depends on dc2d_pkg
module dc2d_checker import dc2d_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [CFGW-1:0]      cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [OPW-1:0]       opcode,
	input  logic [IDXW-1:0]      index,
	input  logic signed [VW-1:0] value,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 kind,
	input  logic                 status,
	input  logic signed [VW-1:0] read_value,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 4096;
	localparam int NUM_CH      = 16;

	typedef struct packed {
		logic                 kind;
		logic                 status;
		logic signed [VW-1:0] rd;
	} conv_result_t;

	// mirrored stores and geometry
	logic signed [VW-1:0] act_mem [STORE_DEPTH];
	logic signed [VW-1:0] wgt_mem [STORE_DEPTH];
	logic signed [VW-1:0] bias_mem [NUM_CH];
	logic signed [VW-1:0] out_mem [STORE_DEPTH];
	logic [4:0] n_ic, n_oc;
	logic [6:0] n_ih, n_iw;
	logic [2:0] n_kh, n_kw, n_stride;
	logic [1:0] n_pad;
	conv_result_t awaited_q[$];
	int err_cnt;

	// Q16.16 to Q8.8, half up, clamped
	function automatic logic signed [VW-1:0] q88_of(input longint acc);
		longint q;
		q = (acc + 128) >>> 8;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[VW-1:0];
	endfunction

	// full convolution over the mirrored stores; returns the status bit
	function automatic logic convolve();
		int sh, sw, oh_n, ow_n, ih, iw;
		longint acc;
		if (n_ic == 0 || n_oc == 0 || n_ih == 0 || n_iw == 0 || n_kh == 0 ||
		    n_kw == 0 || n_stride == 0) return STAT_BAD;
		if (n_ic > NUM_CH || n_oc > NUM_CH) return STAT_BAD;
		sh = n_ih + 2 * n_pad;
		sw = n_iw + 2 * n_pad;
		if (sh < n_kh || sw < n_kw) return STAT_BAD;
		oh_n = (sh - n_kh) / n_stride + 1;
		ow_n = (sw - n_kw) / n_stride + 1;
		if (n_ic * n_ih * n_iw > STORE_DEPTH) return STAT_BAD;
		if (n_oc * n_ic * n_kh * n_kw > STORE_DEPTH) return STAT_BAD;
		if (n_oc * oh_n * ow_n > STORE_DEPTH) return STAT_BAD;
		for (int oc = 0; oc < n_oc; oc++)
			for (int oh = 0; oh < oh_n; oh++)
				for (int ow = 0; ow < ow_n; ow++) begin
					acc = longint'(bias_mem[oc]) * 256;
					for (int ic = 0; ic < n_ic; ic++)
						for (int kh = 0; kh < n_kh; kh++) begin
							ih = oh * n_stride + kh - n_pad;
							if (ih < 0 || ih >= n_ih) continue;
							for (int kw = 0; kw < n_kw; kw++) begin
								iw = ow * n_stride + kw - n_pad;
								if (iw < 0 || iw >= n_iw) continue;
								acc += longint'(act_mem[(ic * n_ih + ih) * n_iw + iw]) *
								       longint'(wgt_mem[((oc * n_ic + ic) * n_kh + kh) * n_kw + kw]);
							end
						end
					out_mem[(oc * oh_n + oh) * ow_n + ow] = q88_of(acc);
				end
		return STAT_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		conv_result_t got, want;
		if (!arst_n) begin
			n_ic = 1; n_oc = 1; n_ih = 28; n_iw = 28;
			n_kh = 5; n_kw = 5; n_stride = 1; n_pad = 0;
			for (int i = 0; i < NUM_CH; i++) bias_mem[i] = '0;
			awaited_q.delete();
			err_cnt = 0;
		end else begin
			// result side
			if (out_valid && !out_stall) begin
				got = '{kind, status, read_value};
				if (awaited_q.size() == 0) begin
					$display("%0t: unexpected result kind=%0d status=%0d value=%0d",
					         $time, kind, status, read_value);
					err_cnt++;
				end else begin
					want = awaited_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected kind=%0d status=%0d value=%0d, got kind=%0d status=%0d value=%0d",
						         $time, want.kind, want.status, want.rd, got.kind, got.status, got.rd);
						err_cnt++;
					end
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_IN_CH:   n_ic = cfg_data[4:0];
					REG_OUT_CH:  n_oc = cfg_data[4:0];
					REG_IN_H:    n_ih = cfg_data[6:0];
					REG_IN_W:    n_iw = cfg_data[6:0];
					REG_K_H:     n_kh = cfg_data[2:0];
					REG_K_W:     n_kw = cfg_data[2:0];
					REG_STRIDE:  n_stride = cfg_data[2:0];
					REG_PADDING: n_pad = cfg_data[1:0];
					default: ;
				endcase
			end
			// item side
			if (in_valid && !in_stall) begin
				case (opcode)
					OP_WR_ACT:  act_mem[index] = value;
					OP_WR_WGT:  wgt_mem[index] = value;
					OP_WR_BIAS: if (index < NUM_CH) bias_mem[index] = value;
					OP_COMPUTE: awaited_q.push_back('{KIND_DONE, convolve(), '0});
					OP_READ:    awaited_q.push_back('{KIND_READ, STAT_OK, out_mem[index]});
					default: ;
				endcase
			end
		end
		errors <= err_cnt;
		pending <= awaited_q.size();
	end

endmodule

>>> tb/tb_direct_conv2d_engine.sv
// testbench top for direct_conv2d_engine: clock, reset, layer stimulus and verdict
// depends on dc2d_pkg, dc2d_checker and the engine itself
module tb_direct_conv2d_engine;
	import dc2d_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int STORE_DEPTH = 4096;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [CFGW-1:0] cfg_data;
	logic in_valid, in_stall;
	logic [OPW-1:0] opcode;
	logic [IDXW-1:0] index;
	logic signed [VW-1:0] value;
	logic out_valid, out_stall;
	logic kind, status;
	logic signed [VW-1:0] read_value;
	int errors, pending;
	int cycles = 0;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int stall_pct = 0;
	int outs_defined = 0;   // output entries below this were written by a good compute
	int n_layers = 0, n_bad = 0, n_reads = 0, n_items = 0;

	direct_conv2d_engine i_dut (.*);

	dc2d_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver back-pressure: random stall level, random long holds, one forced hold
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_pct <= $urandom_range(0, 2) * 30;
			if ($urandom_range(0, 299) == 0) hold_left <= $urandom_range(20, 60);
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// one item, then sometimes a random gap
	task automatic send(input logic [OPW-1:0] op, input int idx, input logic [VW-1:0] val);
		int r;
		in_valid <= 1'b1;
		opcode <= op;
		index <= idx[IDXW-1:0];
		value <= val;
		do @(posedge clk); while (in_stall);
		n_items++;
		r = $urandom_range(0, 99);
		if (r >= 60) begin
			in_valid <= 1'b0;
			if (r < 90) repeat ($urandom_range(1, 3)) @(posedge clk);
			else if (r < 98) repeat ($urandom_range(4, 10)) @(posedge clk);
			else repeat ($urandom_range(20, 60)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [VW-1:0] pick_value(input int vmode);
		case (vmode)
			1: return 16'sh7fff;
			2: return 16'sh8000;
			default: return VW'($urandom_range(0, 1) ? $urandom() :
				$urandom_range(0, 1023) - 512);
		endcase
	endfunction

	// output count of a geometry, 0 when the engine must reject it
	function automatic int out_count(input int g[8]);
		int sh, sw, oh_n, ow_n;
		for (int i = 0; i < 7; i++) if (g[i] == 0) return 0;
		if (g[REG_IN_CH] > 16 || g[REG_OUT_CH] > 16) return 0;
		sh = g[REG_IN_H] + 2 * g[REG_PADDING];
		sw = g[REG_IN_W] + 2 * g[REG_PADDING];
		if (sh < g[REG_K_H] || sw < g[REG_K_W]) return 0;
		oh_n = (sh - g[REG_K_H]) / g[REG_STRIDE] + 1;
		ow_n = (sw - g[REG_K_W]) / g[REG_STRIDE] + 1;
		if (g[REG_IN_CH] * g[REG_IN_H] * g[REG_IN_W] > STORE_DEPTH) return 0;
		if (g[REG_OUT_CH] * g[REG_IN_CH] * g[REG_K_H] * g[REG_K_W] > STORE_DEPTH) return 0;
		if (g[REG_OUT_CH] * oh_n * ow_n > STORE_DEPTH) return 0;
		return g[REG_OUT_CH] * oh_n * ow_n;
	endfunction

	// program the geometry, load every used activation and weight entry and some biases, compute, read back some outputs
	task automatic run_layer(input int g[8], input int n_rd, input int vmode);
		int outs;
		drain();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= g[i][CFGW-1:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		outs = out_count(g);
		n_layers++;
		if (outs > 0) begin
			for (int i = 0; i < g[REG_IN_CH] * g[REG_IN_H] * g[REG_IN_W]; i++)
				send(OP_WR_ACT, i, pick_value(vmode));
			for (int i = 0; i < g[REG_OUT_CH] * g[REG_IN_CH] * g[REG_K_H] * g[REG_K_W]; i++)
				send(OP_WR_WGT, i, pick_value(vmode));
			for (int i = 0; i < g[REG_OUT_CH]; i++)
				if ($urandom_range(0, 1)) send(OP_WR_BIAS, i, pick_value(vmode));
		end else n_bad++;
		send(OP_COMPUTE, $urandom_range(0, STORE_DEPTH - 1), VW'($urandom()));
		if (outs > outs_defined) outs_defined = outs;
		if (outs_defined > 0)
			for (int i = 0; i < n_rd; i++) begin
				send(OP_READ, (i == 0) ? outs_defined - 1 : $urandom_range(0, outs_defined - 1),
				     VW'($urandom()));
				n_reads++;
			end
	endtask

	// ignored items: unused opcodes and bias writes past the channel store
	task automatic noise(input int n);
		for (int i = 0; i < n; i++)
			if ($urandom_range(0, 1))
				send(OPW'($urandom_range(OP_READ + 1, {OPW{1'b1}})), $urandom(),
				     VW'($urandom()));
			else
				send(OP_WR_BIAS, $urandom_range(16, STORE_DEPTH - 1), VW'($urandom()));
	endtask

	initial begin
		int g[8];
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		opcode <= OP_WR_ACT;
		index <= '0;
		value <= '0;
		out_stall <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: padding on both axes with saturating values
		g = '{1, 1, 3, 3, 3, 3, 1, 1};  run_layer(g, 4, 1);
		g = '{1, 1, 3, 3, 3, 3, 1, 1};  run_layer(g, 2, 2);
		// directed: geometries the engine must reject
		g = '{0, 1, 4, 4, 1, 1, 1, 0};  run_layer(g, 1, 0);
		g = '{1, 1, 4, 4, 1, 1, 0, 0};  run_layer(g, 1, 0);
		g = '{17, 1, 4, 4, 1, 1, 1, 0}; run_layer(g, 0, 0);
		g = '{1, 1, 2, 2, 7, 7, 1, 0};  run_layer(g, 0, 0);
		g = '{16, 16, 64, 64, 7, 7, 4, 3}; run_layer(g, 0, 0);
		g = '{2, 1, 64, 64, 1, 1, 1, 0}; run_layer(g, 0, 0);
		g = '{31, 31, 127, 127, 7, 7, 7, 3}; run_layer(g, 0, 0);
		// directed: largest channel counts (rejected by the weight total), largest padding, full output store
		g = '{16, 16, 2, 2, 7, 7, 4, 3}; run_layer(g, 3, 0);
		g = '{1, 16, 10, 10, 1, 1, 1, 3}; run_layer(g, 3, 0);
		noise(6);

		// back-pressure: the receiver holds while reads keep coming
		drain();
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		for (int i = 0; i < 24; i++)
			send(OP_READ, $urandom_range(0, outs_defined - 1), VW'($urandom()));

		// random layers, mostly small
		while (n_items < 850 && n_layers < 70) begin
			g[REG_IN_CH] = $urandom_range(1, 3);
			g[REG_OUT_CH] = $urandom_range(1, 3);
			g[REG_IN_H] = $urandom_range(1, 6);
			g[REG_IN_W] = $urandom_range(1, 6);
			g[REG_K_H] = $urandom_range(1, 4);
			g[REG_K_W] = $urandom_range(1, 4);
			g[REG_STRIDE] = $urandom_range(1, 4);
			g[REG_PADDING] = $urandom_range(0, 3);
			if ($urandom_range(0, 9) == 0) g[$urandom_range(0, 6)] = 0;
			run_layer(g, $urandom_range(2, 10), ($urandom_range(0, 7) == 0) ? 1 : 0);
			if ($urandom_range(0, 3) == 0) noise($urandom_range(1, 4));
		end

		drain();
		$display("covered %0d layers (%0d rejected), %0d reads, %0d items in total",
		         n_layers, n_bad, n_reads, n_items);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
